### hw/rtl/dfr_pkg.sv
// shared types, opcodes and helpers of the detector frame reassembler
package dfr_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] shutter_count;
        logic [15:0] sequence_raw;
        logic [13:0] payload_length;
        logic [7:0]  data_byte;
        logic        last;
        logic [17:0] read_address;
    } dfr_in_t;

    typedef struct packed {
        logic        frame_ready;
        logic [7:0]  read_byte;
        logic [31:0] packets_received;
        logic [31:0] packets_lost;
        logic [31:0] frames_received;
        logic [31:0] frames_skipped;
        logic        filling_store;
    } dfr_out_t;

    localparam logic [1:0] OP_HEADER  = 2'd0;
    localparam logic [1:0] OP_PAYLOAD = 2'd1;
    localparam logic [1:0] OP_READOUT = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    // register index taken from paddr[2]
    localparam logic REG_COUNTER_BITS = 1'b0;

    // frame bytes for a pixel depth, before the store size limit
    function automatic logic [17:0] frame_size_raw(input logic [5:0] bits);
        logic [18:0] s;
        s = 19'd98304;
        if (bits inside {6'd1, 6'd4, 6'd6, 6'd12, 6'd24}) begin
            s = {bits, 13'd0};
        end
        return s[17:0];
    endfunction

endpackage

### hw/rtl/dfr_frame_mem.sv
// frame store memory: both ping-pong stores, one write and one registered read port
module dfr_frame_mem #(
    parameter int AW = 18
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW:0]   waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW:0]   raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [2**(AW+1)];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/dfr_div.sv
// restoring divider, one quotient bit per cycle
module dfr_div #(
    parameter int NW = 19,
    parameter int DW = 15
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    import dfr_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   sh;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh        = {rem_reg, quo_reg[NW-1]};
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sh >= {1'b0, den_reg}) begin
                rem_next = DW'(sh - {1'b0, den_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = sh[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = CW'(cnt_reg + 1'b1);
            if (cnt_reg == CW'(NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

### hw/rtl/detector_frame_reassembler_unit.sv
// Detector frame reassembler: rebuilds frames from sequenced packets into two
// ping-pong frame stores held in one synchronous byte memory.
// Input words (s_valid/s_ready, s_data) are packet headers, payload bytes or
// readout byte accesses; every word yields one result word (m_valid/m_ready,
// m_data) with the statistics counters, the ready flag and the read byte.
// Payload bytes and no-ops are handled in the idle state; a readout passes
// through ST_READ for the registered memory read. A header passes through
// ST_EVAL and ST_MUL; the first header after initialisation, if its payload
// length is nonzero, also waits in ST_DIV for the packets-per-frame division
// in the bit-serial divider. Starting a new frame clears the fill store to
// 0xFF, one byte a cycle over all MAX_FRAME_BYTES addresses, during which no
// word is accepted. After reset both stores are cleared before the first word.
// Results sit in an output register; a word is accepted only when idle and
// that register is empty or being emptied: a stalled receiver holds off input.
// Configuration (counter_bits) goes through the APB port at address 0; the user
// must write it only while the block is idle, the block does not enforce it.
module detector_frame_reassembler_unit #(
    parameter int MAX_FRAME_BYTES   = 262144,
    parameter int MAX_PAYLOAD_BYTES = 16372
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dfr_pkg::dfr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dfr_pkg::dfr_out_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import dfr_pkg::*;

    localparam int AW    = $clog2(MAX_FRAME_BYTES);
    localparam int FB_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int PS_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int NUM_W = $clog2(MAX_FRAME_BYTES + MAX_PAYLOAD_BYTES);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_EVAL  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_CLEAR = 7'b0100000,
        ST_SPARE = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [5:0]         cb_reg, cb_next;
    logic [1:0]         full_reg, full_next;
    logic               fill_reg, fill_next;
    logic [15:0]        exp_shutter_reg, exp_shutter_next;
    logic [16:0]        exp_seq_reg, exp_seq_next;
    logic [FB_W-1:0]    ppf_reg, ppf_next;
    logic [PS_W-1:0]    ps_reg, ps_next;
    logic signed [16:0] cur_seq_reg, cur_seq_next;
    logic [PS_W-1:0]    offset_reg, offset_next;
    logic               open_reg, open_next;
    logic [31:0]        rx_reg, rx_next;
    logic [31:0]        lost_reg, lost_next;
    logic [31:0]        frames_reg, frames_next;
    logic [31:0]        skip_reg, skip_next;
    logic [31:0]        base_reg, base_next;
    logic [15:0]        h_shutter_reg, h_shutter_next;
    logic signed [16:0] h_seq_reg, h_seq_next;
    logic               h_zero_reg, h_zero_next;
    logic               need_clear_reg, need_clear_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               clr_store_reg, clr_store_next;
    logic               clr_both_reg, clr_both_next;
    logic               rd_hit_reg, rd_hit_next;
    logic               m_valid_reg, m_valid_next;
    dfr_out_t           m_data_reg, m_data_next;

    logic               accept;
    logic [31:0]        fs_raw32, fs32, plen32, ps32, addr32, ra32;
    logic               do_ns, load_res, other;
    logic [7:0]         rd_byte;
    logic               mem_we, mem_re;
    logic [AW:0]        mem_waddr, mem_raddr;
    logic [7:0]         mem_wdata, mem_rdata;
    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_num, div_quo;
    logic               cfg_we;

    assign fs_raw32 = 32'(frame_size_raw(cb_reg));
    assign fs32     = (fs_raw32 > 32'(MAX_FRAME_BYTES)) ? 32'(MAX_FRAME_BYTES) : fs_raw32;
    assign plen32   = 32'(s_data.payload_length);
    assign ps32     = (plen32 > 32'(MAX_PAYLOAD_BYTES)) ? 32'(MAX_PAYLOAD_BYTES) : plen32;
    assign addr32   = base_reg + 32'(offset_reg);
    assign ra32     = 32'(s_data.read_address);
    assign div_num  = NUM_W'(fs32 + ps32 - 32'd1);

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_COUNTER_BITS);
    assign prdata = (paddr[2] == REG_COUNTER_BITS) ? {26'd0, cb_reg} : 32'd0;

    always_comb begin
        state_next       = state_reg;
        cb_next          = cfg_we ? pwdata[5:0] : cb_reg;
        full_next        = full_reg;
        fill_next        = fill_reg;
        exp_shutter_next = exp_shutter_reg;
        exp_seq_next     = exp_seq_reg;
        ppf_next         = ppf_reg;
        ps_next          = ps_reg;
        cur_seq_next     = cur_seq_reg;
        offset_next      = offset_reg;
        open_next        = open_reg;
        rx_next          = rx_reg;
        lost_next        = lost_reg;
        frames_next      = frames_reg;
        skip_next        = skip_reg;
        base_next        = base_reg;
        h_shutter_next   = h_shutter_reg;
        h_seq_next       = h_seq_reg;
        h_zero_next      = h_zero_reg;
        need_clear_next  = need_clear_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_store_next   = clr_store_reg;
        clr_both_next    = clr_both_reg;
        rd_hit_next      = rd_hit_reg;
        m_valid_next     = m_ready ? 1'b0 : m_valid_reg;
        m_data_next      = m_data_reg;
        do_ns            = 1'b0;
        load_res         = 1'b0;
        rd_byte          = 8'd0;
        mem_we           = 1'b0;
        mem_waddr        = {fill_reg, addr32[AW-1:0]};
        mem_wdata        = s_data.data_byte;
        mem_re           = 1'b0;
        mem_raddr        = {~fill_reg, ra32[AW-1:0]};
        div_start        = 1'b0;
        other            = ~fill_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.opcode)
                        OP_HEADER: begin
                            h_shutter_next = s_data.shutter_count;
                            h_seq_next     = $signed({1'b0, s_data.sequence_raw}) - 17'sd1;
                            h_zero_next    = (s_data.payload_length == 14'd0);
                            state_next     = ST_EVAL;
                            if (exp_shutter_reg == 16'd0) begin
                                exp_shutter_next = s_data.shutter_count;
                                ps_next          = ps32[PS_W-1:0];
                                if (ps32 == 32'd0) begin
                                    ppf_next = FB_W'(fs32);
                                end else begin
                                    div_start  = 1'b1;
                                    state_next = ST_DIV;
                                end
                            end
                        end
                        OP_PAYLOAD: begin
                            load_res = 1'b1;
                            if (open_reg) begin
                                if (!cur_seq_reg[16] &&
                                    32'(cur_seq_reg[15:0]) < 32'(ppf_reg) &&
                                    32'(offset_reg) < 32'(MAX_PAYLOAD_BYTES) &&
                                    addr32 < fs32) begin
                                    mem_we = 1'b1;
                                end
                                if (32'(offset_reg) < 32'(MAX_PAYLOAD_BYTES)) begin
                                    offset_next = PS_W'(offset_reg + 1'b1);
                                end
                                if (s_data.last) begin
                                    open_next   = 1'b0;
                                    offset_next = '0;
                                    if (32'(exp_seq_reg) == 32'(ppf_reg)) begin
                                        frames_next = frames_reg + 32'd1;
                                        do_ns       = 1'b1;
                                    end
                                end
                            end
                        end
                        OP_READOUT: begin
                            mem_re      = 1'b1;
                            rd_hit_next = full_reg[other] && (ra32 < fs32);
                            if (full_reg[other] && s_data.last) begin
                                full_next[other] = 1'b0;
                            end
                            state_next = ST_READ;
                        end
                        default: begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    ppf_next   = FB_W'(div_quo);
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                rx_next         = rx_reg + 32'd1;
                need_clear_next = 1'b0;
                if (h_shutter_reg != exp_shutter_reg ||
                    h_seq_reg < $signed({1'b0, exp_seq_reg})) begin
                    exp_shutter_next = h_shutter_reg;
                    if (32'(exp_seq_reg) != 32'(ppf_reg)) begin
                        frames_next     = frames_reg + 32'd1;
                        do_ns           = 1'b1;
                        need_clear_next = 1'b1;
                    end
                    lost_next = lost_reg + 32'(ppf_reg) - 32'(exp_seq_reg) + 32'(h_seq_reg);
                end else if (h_seq_reg > $signed({1'b0, exp_seq_reg})) begin
                    lost_next = lost_reg + 32'(h_seq_reg) - 32'(exp_seq_reg);
                end
                exp_seq_next = 17'(h_seq_reg + 17'sd1);
                cur_seq_next = h_seq_reg;
                offset_next  = '0;
                open_next    = !h_zero_reg;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                base_next = 32'(cur_seq_reg[15:0]) * 32'(ps_reg);
                load_res  = 1'b1;
                if (h_zero_reg && 32'(exp_seq_reg) == 32'(ppf_reg)) begin
                    frames_next = frames_reg + 32'd1;
                    do_ns       = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_READ: begin
                load_res   = 1'b1;
                rd_byte    = rd_hit_reg ? mem_rdata : 8'd0;
                state_next = ST_IDLE;
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {clr_store_reg, clr_cnt_reg};
                mem_wdata = 8'hFF;
                if (clr_cnt_reg == AW'(MAX_FRAME_BYTES - 1)) begin
                    clr_cnt_next = '0;
                    if (clr_both_reg && !clr_store_reg) begin
                        clr_store_next = 1'b1;
                    end else begin
                        clr_both_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    clr_cnt_next = AW'(clr_cnt_reg + 1'b1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // hand the filled store over, or skip when the other is still unread
        if (do_ns) begin
            if (!full_next[other]) begin
                full_next[fill_reg] = 1'b1;
                fill_next           = other;
            end else begin
                skip_next = skip_reg + 32'd1;
            end
        end

        // only the final fill store needs wiping, once per word
        if (load_res && (do_ns || (state_reg == ST_MUL && need_clear_reg))) begin
            clr_cnt_next   = '0;
            clr_store_next = fill_next;
            clr_both_next  = 1'b0;
            state_next     = ST_CLEAR;
        end

        if (load_res) begin
            m_valid_next                 = 1'b1;
            m_data_next.frame_ready      = full_next[~fill_next];
            m_data_next.read_byte        = rd_byte;
            m_data_next.packets_received = rx_next;
            m_data_next.packets_lost     = lost_next;
            m_data_next.frames_received  = frames_next;
            m_data_next.frames_skipped   = skip_next;
            m_data_next.filling_store    = fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            cb_reg          <= 6'd12;
            full_reg        <= 2'b00;
            fill_reg        <= 1'b0;
            exp_shutter_reg <= 16'd0;
            exp_seq_reg     <= 17'd0;
            ppf_reg         <= FB_W'(1);
            ps_reg          <= '0;
            cur_seq_reg     <= 17'sd0;
            offset_reg      <= '0;
            open_reg        <= 1'b0;
            rx_reg          <= 32'd0;
            lost_reg        <= 32'd0;
            frames_reg      <= 32'd0;
            skip_reg        <= 32'd0;
            need_clear_reg  <= 1'b0;
            clr_cnt_reg     <= '0;
            clr_store_reg   <= 1'b0;
            clr_both_reg    <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cb_reg          <= cb_next;
            full_reg        <= full_next;
            fill_reg        <= fill_next;
            exp_shutter_reg <= exp_shutter_next;
            exp_seq_reg     <= exp_seq_next;
            ppf_reg         <= ppf_next;
            ps_reg          <= ps_next;
            cur_seq_reg     <= cur_seq_next;
            offset_reg      <= offset_next;
            open_reg        <= open_next;
            rx_reg          <= rx_next;
            lost_reg        <= lost_next;
            frames_reg      <= frames_next;
            skip_reg        <= skip_next;
            need_clear_reg  <= need_clear_next;
            clr_cnt_reg     <= clr_cnt_next;
            clr_store_reg   <= clr_store_next;
            clr_both_reg    <= clr_both_next;
            m_valid_reg     <= m_valid_next;
        end
        base_reg      <= base_next;
        h_shutter_reg <= h_shutter_next;
        h_seq_reg     <= h_seq_next;
        h_zero_reg    <= h_zero_next;
        rd_hit_reg    <= rd_hit_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    dfr_div #(
        .NW(NUM_W),
        .DW(PS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (ps32[PS_W-1:0]),
        .done    (div_done),
        .quo     (div_quo)
    );

    dfr_frame_mem #(
        .AW(AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );
endmodule
